[design/rational_arith_reduce_defines.svh]
// Assertion macros shared by the rational reduction block.
// RAR_ASSERT_CLK names its clock and active-low reset explicitly.
// RAR_ASSERT uses the block's own clk and arst_n.
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH
`ifndef SYNTHESIS
`define RAR_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);
`define RAR_ASSERT(lbl, prop, msg) `RAR_ASSERT_CLK(lbl, clk, arst_n, prop, msg)
`else
`define RAR_ASSERT_CLK(lbl, clk_sig, rst_n_sig, prop, msg)
`define RAR_ASSERT(lbl, prop, msg)
`endif
`endif

[design/rar_pkg.sv]
package rar_pkg;

	// Default width of one numerator or denominator part.
	localparam int PART_WIDTH_DEF = 16;

	// Operation codes carried on the request channel.
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_MUL4,
		ST_CHECK,
		ST_TWOS,
		ST_ODD,
		ST_GCD,
		ST_SCALE,
		ST_DIVN,
		ST_DIVD,
		ST_FIN
	} state_t;

endpackage

[design/rar_in_if.sv]
// Request channel: an operation and two fractions.
interface rar_in_if #(
	parameter int PART_WIDTH = rar_pkg::PART_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   operation;
	logic signed [PART_WIDTH-1:0] num_first;
	logic signed [PART_WIDTH-1:0] den_first;
	logic signed [PART_WIDTH-1:0] num_second;
	logic signed [PART_WIDTH-1:0] den_second;

	modport source (
		output valid, operation, num_first, den_first, num_second, den_second,
		input  ready
	);

	modport sink (
		input  valid, operation, num_first, den_first, num_second, den_second,
		output ready
	);
endinterface

[design/rar_out_if.sv]
// Response channel: the reduced fraction and its status.
interface rar_out_if #(
	parameter int PART_WIDTH = rar_pkg::PART_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [2*PART_WIDTH:0] num_result;
	logic [2*PART_WIDTH-1:0]      den_result;
	logic                         status;

	modport source (
		output valid, num_result, den_result, status,
		input  ready
	);

	modport sink (
		input  valid, num_result, den_result, status,
		output ready
	);
endinterface

[design/rational_arith_reduce.sv]
// Combines two signed fractions by add, subtract, multiply or divide and
// returns the result in lowest terms with a positive denominator. One request
// beat produces one response beat. The block works on one item at a time and
// drops ready from the beat it accepts until the result is loaded into the
// output register. An item runs its cross products on one shared multiplier,
// a check step, a binary GCD loop on one shared subtractor (halving,
// subtraction and swap steps), a scaling step and two restoring divisions
// by the GCD, then hands the result over. A zero denominator in either input
// skips all of this and returns 0/1 with status set; a zero raw denominator
// does the same after the products.
`include "rational_arith_reduce_defines.svh"

module rational_arith_reduce #(
	parameter int PART_WIDTH = rar_pkg::PART_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rar_in_if.sink     req,
	rar_out_if.source  rsp
);

	localparam int PW = PART_WIDTH;
	localparam int MW = 2 * PART_WIDTH;
	localparam int NW = 2 * PART_WIDTH + 1;
	localparam int CW = $clog2(MW);

	rar_pkg::state_t state_q;
	rar_pkg::state_t state_d;

	// Latched request.
	rar_pkg::op_t      op_q;
	logic signed [PW-1:0] na_q;
	logic signed [PW-1:0] da_q;
	logic signed [PW-1:0] nb_q;
	logic signed [PW-1:0] db_q;

	// Raw result and reduction datapath.
	logic signed [NW-1:0] rn_q;
	logic signed [MW-1:0] rd_q;
	logic [MW-1:0]        u_q;
	logic [MW-1:0]        v_q;
	logic [MW-1:0]        md_q;
	logic [MW-1:0]        dvd_q;
	logic [MW-1:0]        rem_q;
	logic [MW-1:0]        qn_q;
	logic [MW-1:0]        qd_q;
	logic [CW-1:0]        cnt_q;
	logic                 neg_q;
	logic                 err_q;

	// Output register.
	logic                 rsp_valid_q;
	logic signed [NW-1:0] rsp_num_q;
	logic [MW-1:0]        rsp_den_q;
	logic                 rsp_stat_q;

	// Combinational controls.
	logic signed [PW-1:0] mul_x;
	logic signed [PW-1:0] mul_y;
	logic signed [MW-1:0] prod;
	logic [MW:0]          sub_a;
	logic [MW:0]          sub_d;
	logic                 sub_borrow;
	logic                 fin_load;
	logic                 div_last;
	logic                 in_den_zero;
	logic                 op_addsub;

	logic signed [NW-1:0] rn_ext_prod;
	logic signed [NW-1:0] rn_neg;
	logic signed [MW-1:0] rd_neg;
	logic [MW-1:0]        rn_mag;
	logic [MW-1:0]        rd_mag;
	logic [NW-1:0]        qn_ext;
	logic [MW-1:0]        quot_next;
	logic [MW-1:0]        rem_next;

	rar_mult #(
		.PART_WIDTH(PART_WIDTH)
	) u_mult (
		.clk     (clk),
		.mul_x   (mul_x),
		.mul_y   (mul_y),
		.prod_s1 (prod)
	);

	// Shared subtractor: GCD step and division trial both subtract u_q.
	assign sub_d      = sub_a - {1'b0, u_q};
	assign sub_borrow = sub_d[MW];

	// Helper values for the products, magnitudes and result sign.
	assign in_den_zero = (req.den_first == '0) || (req.den_second == '0);
	assign op_addsub   = (op_q == rar_pkg::OP_ADD) || (op_q == rar_pkg::OP_SUB);
	assign rn_ext_prod = {prod[MW-1], prod};
	assign rn_neg      = -rn_q;
	assign rd_neg      = -rd_q;
	assign rn_mag      = rn_q[NW-1] ? rn_neg[MW-1:0] : rn_q[MW-1:0];
	assign rd_mag      = rd_q[MW-1] ? rd_neg : rd_q;
	assign qn_ext      = {1'b0, qn_q};

	// One restoring division step.
	assign quot_next = {dvd_q[MW-2:0], ~sub_borrow};
	assign rem_next  = sub_borrow ? {rem_q[MW-2:0], dvd_q[MW-1]} : sub_d[MW-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rar_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = in_den_zero ? rar_pkg::ST_FIN : rar_pkg::ST_MUL1;
				end
			end
			rar_pkg::ST_MUL1: state_d = rar_pkg::ST_MUL2;
			rar_pkg::ST_MUL2: state_d = rar_pkg::ST_MUL3;
			rar_pkg::ST_MUL3: state_d = op_addsub ? rar_pkg::ST_MUL4 : rar_pkg::ST_CHECK;
			rar_pkg::ST_MUL4: state_d = rar_pkg::ST_CHECK;
			rar_pkg::ST_CHECK: begin
				if (rd_q == '0 || rn_q == '0) begin
					state_d = rar_pkg::ST_FIN;
				end else begin
					state_d = rar_pkg::ST_TWOS;
				end
			end
			rar_pkg::ST_TWOS: begin
				if (u_q[0] || v_q[0]) begin
					state_d = rar_pkg::ST_ODD;
				end
			end
			rar_pkg::ST_ODD: begin
				if (u_q[0]) begin
					state_d = rar_pkg::ST_GCD;
				end
			end
			rar_pkg::ST_GCD: begin
				if (v_q == '0) begin
					state_d = rar_pkg::ST_SCALE;
				end
			end
			rar_pkg::ST_SCALE: state_d = rar_pkg::ST_DIVN;
			rar_pkg::ST_DIVN: begin
				if (div_last) begin
					state_d = rar_pkg::ST_DIVD;
				end
			end
			rar_pkg::ST_DIVD: begin
				if (div_last) begin
					state_d = rar_pkg::ST_FIN;
				end
			end
			rar_pkg::ST_FIN: begin
				if (fin_load) begin
					state_d = rar_pkg::ST_IDLE;
				end
			end
			default: state_d = rar_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, multiplier operands, subtractor operand.
	always_comb begin
		req.ready = 1'b0;
		mul_x     = da_q;
		mul_y     = db_q;
		sub_a     = {1'b0, v_q};
		fin_load  = 1'b0;
		div_last  = (cnt_q == CW'(MW - 1));
		case (state_q)
			rar_pkg::ST_IDLE: req.ready = 1'b1;
			rar_pkg::ST_MUL1: begin
				mul_x = na_q;
				mul_y = (op_q == rar_pkg::OP_MUL) ? nb_q : db_q;
			end
			rar_pkg::ST_MUL2: begin
				mul_x = da_q;
				mul_y = (op_q == rar_pkg::OP_MUL) ? db_q : nb_q;
			end
			rar_pkg::ST_DIVN, rar_pkg::ST_DIVD: sub_a = {rem_q, dvd_q[MW-1]};
			rar_pkg::ST_FIN: fin_load = !rsp_valid_q || rsp.ready;
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rar_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, stepped by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			rar_pkg::ST_IDLE: begin
				if (req.valid) begin
					op_q  <= rar_pkg::op_t'(req.operation);
					na_q  <= req.num_first;
					da_q  <= req.den_first;
					nb_q  <= req.num_second;
					db_q  <= req.den_second;
					qn_q  <= '0;
					qd_q  <= MW'(1);
					neg_q <= 1'b0;
					err_q <= in_den_zero;
				end
			end
			rar_pkg::ST_MUL2: rn_q <= rn_ext_prod;
			rar_pkg::ST_MUL3: begin
				case (op_q)
					rar_pkg::OP_ADD: rn_q <= rn_q + rn_ext_prod;
					rar_pkg::OP_SUB: rn_q <= rn_q - rn_ext_prod;
					default:         rd_q <= prod;
				endcase
			end
			rar_pkg::ST_MUL4: rd_q <= prod;
			rar_pkg::ST_CHECK: begin
				// A zero raw denominator is an error; a zero numerator is 0/1.
				if (rd_q == '0) begin
					err_q <= 1'b1;
				end else if (rn_q != '0) begin
					u_q   <= rn_mag;
					v_q   <= rd_mag;
					dvd_q <= rn_mag;
					md_q  <= rd_mag;
					neg_q <= rn_q[NW-1] ^ rd_q[MW-1];
					cnt_q <= '0;
				end
			end
			rar_pkg::ST_TWOS: begin
				// Strip common factors of two, counting them.
				if (!u_q[0] && !v_q[0]) begin
					u_q   <= u_q >> 1;
					v_q   <= v_q >> 1;
					cnt_q <= cnt_q + CW'(1);
				end
			end
			rar_pkg::ST_ODD: begin
				if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end
			end
			rar_pkg::ST_GCD: begin
				// u stays odd; halve v, swap, or replace v by (v - u) / 2.
				if (v_q != '0) begin
					if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (sub_borrow) begin
						u_q <= v_q;
						v_q <= u_q;
					end else begin
						v_q <= sub_d[MW:1];
					end
				end
			end
			rar_pkg::ST_SCALE: begin
				u_q   <= u_q << cnt_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			rar_pkg::ST_DIVN: begin
				if (div_last) begin
					qn_q  <= quot_next;
					dvd_q <= md_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
					dvd_q <= quot_next;
					rem_q <= rem_next;
				end
			end
			rar_pkg::ST_DIVD: begin
				cnt_q <= cnt_q + CW'(1);
				dvd_q <= quot_next;
				rem_q <= rem_next;
				if (div_last) begin
					qd_q <= quot_next;
				end
			end
			default: ;
		endcase

		// Result beat into the output register.
		if (fin_load) begin
			rsp_num_q  <= neg_q ? -qn_ext : qn_ext;
			rsp_den_q  <= qd_q;
			rsp_stat_q <= err_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.num_result = rsp_num_q;
	assign rsp.den_result = rsp_den_q;
	assign rsp.status     = rsp_stat_q;

	// Checks on the sequencer and datapath.
	`RAR_ASSERT(a_gcd_u_odd, (state_q == rar_pkg::ST_GCD) |-> u_q[0], "GCD divisor not odd")
	`RAR_ASSERT(a_div_rem_below, (state_q == rar_pkg::ST_DIVN || state_q == rar_pkg::ST_DIVD) |-> (rem_q < u_q), "division remainder not below divisor")
	`RAR_ASSERT(a_err_zero, (rsp_valid_q && rsp_stat_q) |-> (rsp_num_q == '0 && rsp_den_q == MW'(1)), "error beat is not 0/1")
	`RAR_ASSERT(a_den_nonzero, rsp_valid_q |-> (rsp_den_q != '0), "zero denominator in response")
	`RAR_ASSERT(a_fin_waits, (state_q == rar_pkg::ST_FIN && rsp_valid_q && !rsp.ready) |=> (state_q == rar_pkg::ST_FIN), "result overran a pending beat")

endmodule

[design/rar_mult.sv]
// Registered signed multiplier shared by the cross products of an item.
module rar_mult #(
	parameter int PART_WIDTH = rar_pkg::PART_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic signed [PART_WIDTH-1:0]   mul_x,
	input  logic signed [PART_WIDTH-1:0]   mul_y,
	output logic signed [2*PART_WIDTH-1:0] prod_s1
);

	// One product per cycle, registered before use.
	always_ff @(posedge clk) begin
		prod_s1 <= mul_x * mul_y;
	end

endmodule

[sim/rational_arith_reduce_tb.sv]
module rational_arith_reduce_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PW          = rar_pkg::PART_WIDTH_DEF;
	localparam int RAND_ITEMS  = 1700;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;
	localparam int MAX_PRINTS  = 40;
	localparam int CALM_FROM   = 40000;
	localparam int CALM_TO     = 70000;

	typedef struct {
		rar_pkg::op_t         op;
		logic signed [PW-1:0] na;
		logic signed [PW-1:0] da;
		logic signed [PW-1:0] nb;
		logic signed [PW-1:0] db;
		bit                   hold_off;
	} request_t;

	typedef struct {
		logic signed [2*PW:0] num;
		logic [2*PW-1:0]      den;
		logic                 status;
	} fraction_t;

	logic clk;
	logic arst_n;

	rar_in_if  #(.PART_WIDTH(PW)) req_ch ();
	rar_out_if #(.PART_WIDTH(PW)) rsp_ch ();

	rational_arith_reduce #(.PART_WIDTH(PW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	request_t  request_q[$];
	fraction_t reduced_q[$];
	int        sent_cnt;
	int        got_cnt;
	int        cycle_cnt;
	int        errors;
	logic      calm;

	// Clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Cycle count; both sides stop idling inside one window of the run.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_cnt <= 0;
		end else begin
			cycle_cnt <= cycle_cnt + 1;
		end
	end

	assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

	// Exact combination of two fractions, then reduction to lowest terms.
	function automatic fraction_t reduce_fraction(request_t r);
		longint          na, da, nb, db, rn, rd, signed_num;
		longint unsigned mn, md, x, y, t;
		fraction_t       f;
		na = r.na;
		da = r.da;
		nb = r.nb;
		db = r.db;
		f.num = '0;
		f.den = 1;
		f.status = 1'b0;
		if (da == 0 || db == 0) begin
			f.status = 1'b1;
			return f;
		end
		case (r.op)
			rar_pkg::OP_ADD: begin
				rn = na * db + da * nb;
				rd = da * db;
			end
			rar_pkg::OP_SUB: begin
				rn = na * db - da * nb;
				rd = da * db;
			end
			rar_pkg::OP_MUL: begin
				rn = na * nb;
				rd = da * db;
			end
			default: begin
				rn = na * db;
				rd = da * nb;
			end
		endcase
		// Dividing by a fraction with a zero numerator leaves a zero denominator.
		if (rd == 0) begin
			f.status = 1'b1;
			return f;
		end
		if (rn == 0) begin
			return f;
		end
		mn = (rn < 0) ? longint'(-rn) : longint'(rn);
		md = (rd < 0) ? longint'(-rd) : longint'(rd);
		x = mn;
		y = md;
		while (x != 0) begin
			t = y % x;
			y = x;
			x = t;
		end
		mn = mn / y;
		md = md / y;
		signed_num = ((rn < 0) != (rd < 0)) ? -longint'(mn) : longint'(mn);
		f.num = signed_num[2*PW:0];
		f.den = md[2*PW-1:0];
		return f;
	endfunction

	function automatic request_t make_request(rar_pkg::op_t op, int na, int da, int nb, int db,
			bit hold);
		request_t r;
		r.op = op;
		r.na = na[PW-1:0];
		r.da = da[PW-1:0];
		r.nb = nb[PW-1:0];
		r.db = db[PW-1:0];
		r.hold_off = hold;
		return r;
	endfunction

	// One random part: full-range words, small or related values so that
	// reductions happen, extremes and powers of two.
	function automatic logic [PW-1:0] pick_part();
		int          mode;
		int          v;
		logic [31:0] w;
		mode = $urandom_range(0, 9);
		w = $urandom;
		case (mode)
			0, 1, 2, 3: v = w;
			4, 5, 6:    v = $urandom_range(0, 40) - 20;
			7: begin
				case ($urandom_range(0, 4))
					0:       v = -(1 << (PW - 1));
					1:       v = (1 << (PW - 1)) - 1;
					2:       v = -1;
					3:       v = 1;
					default: v = 0;
				endcase
			end
			8: v = ($urandom_range(1, 60) * $urandom_range(1, 500)) * (w[0] ? -1 : 1);
			default: v = (1 << $urandom_range(0, PW - 2)) * (w[0] ? -1 : 1);
		endcase
		return v[PW-1:0];
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		errors++;
		if (errors <= MAX_PRINTS) begin
			$display("mismatch in %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		end
	endtask

	// Request driver: presents the oldest pending item, holds it while stalled,
	// and records the expected fraction when the beat is taken.
	always @(posedge clk or negedge arst_n) begin : req_driver
		int  sent_now;
		bit  go;
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.operation  <= '0;
			req_ch.num_first  <= '0;
			req_ch.den_first  <= '0;
			req_ch.num_second <= '0;
			req_ch.den_second <= '0;
			sent_cnt          <= 0;
		end else begin
			sent_now = sent_cnt;
			if (req_ch.valid && req_ch.ready) begin
				reduced_q.push_back(reduce_fraction(request_q.pop_front()));
				sent_now = sent_cnt + 1;
				sent_cnt <= sent_now;
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				go = (request_q.size() > 0) && (calm || $urandom_range(0, 99) >= 30);
				// A held-off item waits until every earlier result is back.
				if (go && request_q[0].hold_off && sent_now != got_cnt) begin
					go = 1'b0;
				end
				if (go) begin
					req_ch.valid      <= 1'b1;
					req_ch.operation  <= request_q[0].op;
					req_ch.num_first  <= request_q[0].na;
					req_ch.den_first  <= request_q[0].da;
					req_ch.num_second <= request_q[0].nb;
					req_ch.den_second <= request_q[0].db;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: checks each beat against the oldest expected fraction.
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		fraction_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			got_cnt      <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_cnt <= got_cnt + 1;
				if (reduced_q.size() == 0) begin
					report_mismatch("unexpected result beat", 0, $signed(rsp_ch.num_result));
				end else begin
					want = reduced_q.pop_front();
					if (rsp_ch.num_result !== want.num) begin
						report_mismatch("num_result", want.num, $signed(rsp_ch.num_result));
					end
					if (rsp_ch.den_result !== want.den) begin
						report_mismatch("den_result", longint'(want.den), longint'(rsp_ch.den_result));
					end
					if (rsp_ch.status !== want.status) begin
						report_mismatch("status", want.status, rsp_ch.status);
					end
				end
			end
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 30);
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (arst_n && !(req_ch.valid && req_ch.ready) && !(rsp_ch.valid && rsp_ch.ready)) begin
				quiet++;
			end else begin
				quiet = 0;
			end
		end
		$display("rational_arith_reduce_tb: FAIL");
		$finish;
	end

	// Stimulus and end of run.
	initial begin : stimulus
		request_t r;
		int       lo, hi;
		lo = -(1 << (PW - 1));
		hi = (1 << (PW - 1)) - 1;
		errors = 0;
		arst_n = 1'b0;

		// Directed items: each operation, zero denominators, zero numerators,
		// signs on the denominators and the extremes of every part.
		request_q.push_back(make_request(rar_pkg::OP_ADD, 1, 2, 1, 3, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_SUB, 1, 2, 1, 2, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_MUL, 6, 35, 14, 15, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_DIV, 3, 4, -9, 8, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_ADD, 5, 0, 1, 3, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_MUL, 5, 7, 1, 0, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_DIV, 0, 0, 0, 0, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_DIV, 7, 3, 0, 5, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_ADD, 0, -5, 0, 7, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_SUB, -3, -4, 5, -6, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_MUL, 0, 9, 4, -2, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_ADD, lo, lo, lo, lo, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_SUB, lo, lo, lo, lo, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_MUL, lo, 1, lo, 1, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_DIV, lo, 1, 1, lo, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_ADD, hi, hi, hi, hi, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_ADD, lo, hi, lo, hi - 2, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_SUB, lo, hi, hi, lo, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_MUL, hi, lo, hi, lo, 1'b1));
		request_q.push_back(make_request(rar_pkg::OP_DIV, lo, hi, hi, lo, 1'b0));
		request_q.push_back(make_request(rar_pkg::OP_DIV, -1, -1, -1, -1, 1'b0));

		// Random items.
		repeat (RAND_ITEMS) begin
			r.op = rar_pkg::op_t'($urandom_range(0, 3));
			r.na = pick_part();
			r.da = pick_part();
			r.nb = pick_part();
			r.db = pick_part();
			r.hold_off = ($urandom_range(0, 149) == 0);
			request_q.push_back(r);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Both queues move in the same step as the beat, so this cannot race.
		do begin
			@(posedge clk);
		end while (request_q.size() != 0 || reduced_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (reduced_q.size() != 0) begin
			report_mismatch("results never returned", reduced_q.size(), 0);
		end
		if (errors == 0) begin
			$display("rational_arith_reduce_tb: PASS");
		end else begin
			$display("rational_arith_reduce_tb: FAIL");
		end
		$finish;
	end

endmodule
